// ===== rtl/tlr_pkg.sv =====
package tlr_pkg;

  localparam int MAP_LAST_COLUMN_DEF = 32;
  localparam int MAP_LAST_ROW_DEF    = 24;
  localparam int SCREEN_WIDTH_DEF    = 256;
  localparam int SCREEN_HEIGHT_DEF   = 192;
  localparam int TILE_COUNT_DEF      = 512;

  localparam int BYTES_PER_TILE = 8 * 8 / 2;
  localparam int PALETTE_SIZE   = 256;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CELL_W         = 13;

  localparam logic CFG_SCROLL_X = 1'b0;
  localparam logic CFG_SCROLL_Y = 1'b1;

  typedef enum logic [1:0] {
    ACT_TILE   = 2'd0,
    ACT_MAP    = 2'd1,
    ACT_PAL    = 2'd2,
    ACT_RENDER = 2'd3
  } tlr_action_t;

  // en: write address in range, or render pixel covered by the map
  // addr: write address, or map cell index for a render
  // pix: {row in tile, column in tile} for a render
  typedef struct packed {
    tlr_action_t  action;
    logic         en;
    logic [13:0]  addr;
    logic [31:0]  data;
    logic [5:0]   pix;
  } tlr_item_t;

endpackage

// ===== rtl/tlr_front.sv =====
module tlr_front #(
  parameter int MAP_LAST_COLUMN = tlr_pkg::MAP_LAST_COLUMN_DEF,
  parameter int MAP_LAST_ROW    = tlr_pkg::MAP_LAST_ROW_DEF,
  parameter int SCREEN_WIDTH    = tlr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT   = tlr_pkg::SCREEN_HEIGHT_DEF,
  parameter int TILE_COUNT      = tlr_pkg::TILE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic [13:0]         in_address,
  input  logic [31:0]         in_value,
  input  logic [7:0]          in_attrib,
  input  logic [7:0]          in_screen_x,
  input  logic [7:0]          in_screen_y,
  input  logic                q_full,
  input  logic                busy,
  output logic                q_push,
  output tlr_pkg::tlr_item_t  q_item
);
  import tlr_pkg::*;

  localparam int MAP_COLUMNS   = MAP_LAST_COLUMN + 1;
  localparam int MAP_CELLS     = MAP_COLUMNS * (MAP_LAST_ROW + 1);
  localparam int TILESET_BYTES = TILE_COUNT * BYTES_PER_TILE;

  logic [7:0]  scroll_x_r, scroll_x_nxt;
  logic [7:0]  scroll_y_r, scroll_y_nxt;
  logic [8:0]  px, py;
  logic [5:0]  col, row;
  logic        on_screen, covered;
  logic [11:0] cell_idx;
  tlr_action_t act;

  always_comb begin
    scroll_x_nxt = scroll_x_r;
    scroll_y_nxt = scroll_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCROLL_X: scroll_x_nxt = cfg_wdata;
        CFG_SCROLL_Y: scroll_y_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r <= '0;
      scroll_y_r <= '0;
    end else begin
      scroll_x_r <= scroll_x_nxt;
      scroll_y_r <= scroll_y_nxt;
    end
  end

  assign in_stall = busy || q_full;
  assign q_push   = in_valid && !in_stall;
  assign act      = tlr_action_t'(in_action);

  assign px        = {1'b0, in_screen_x} + {1'b0, scroll_x_r};
  assign py        = {1'b0, in_screen_y} + {1'b0, scroll_y_r};
  assign col       = px[8:3];
  assign row       = py[8:3];
  assign on_screen = ({1'b0, in_screen_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, in_screen_y} < 9'(SCREEN_HEIGHT));
  assign covered   = on_screen && (col <= 6'(MAP_LAST_COLUMN)) &&
                     (row <= 6'(MAP_LAST_ROW));
  assign cell_idx  = 12'(row) * 12'(MAP_COLUMNS) + 12'(col);

  always_comb begin
    q_item.action = act;
    q_item.addr   = in_address;
    q_item.data   = in_value;
    q_item.pix    = {py[2:0], px[2:0]};
    q_item.en     = 1'b0;
    unique case (act)
      ACT_TILE: q_item.en = {1'b0, in_address} < 15'(TILESET_BYTES);
      ACT_MAP: begin
        q_item.en   = {1'b0, in_address} < 15'(MAP_CELLS);
        q_item.data = {19'd0, in_attrib[7:4], in_attrib[0], in_value[7:0]};
      end
      ACT_PAL: q_item.en = {1'b0, in_address} < 15'(PALETTE_SIZE);
      ACT_RENDER: begin
        q_item.en   = covered;
        q_item.addr = covered ? 14'(cell_idx) : '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/tlr_queue.sv =====
module tlr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tlr_pkg::tlr_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output tlr_pkg::tlr_item_t  pop_item,
  output logic                empty
);
  import tlr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tlr_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/tlr_back.sv =====
module tlr_back #(
  parameter int MAP_LAST_COLUMN = tlr_pkg::MAP_LAST_COLUMN_DEF,
  parameter int MAP_LAST_ROW    = tlr_pkg::MAP_LAST_ROW_DEF,
  parameter int TILE_COUNT      = tlr_pkg::TILE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tlr_pkg::tlr_item_t  q_item,
  output logic                q_pop,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_color,
  output logic                out_covered
);
  import tlr_pkg::*;

  localparam int MAP_CELLS     = (MAP_LAST_COLUMN + 1) * (MAP_LAST_ROW + 1);
  localparam int TILESET_BYTES = TILE_COUNT * BYTES_PER_TILE;
  localparam int TILE_ADDR_W   = $clog2(TILESET_BYTES);
  localparam int MAP_IDX_W     = $clog2(MAP_CELLS);
  localparam int CLR_DEPTH0    = (TILESET_BYTES > MAP_CELLS) ? TILESET_BYTES : MAP_CELLS;
  localparam int CLR_DEPTH     = (CLR_DEPTH0 > PALETTE_SIZE) ? CLR_DEPTH0 : PALETTE_SIZE;
  localparam int CLR_W         = $clog2(CLR_DEPTH);

  logic [7:0]        tile_mem [TILESET_BYTES];
  logic [CELL_W-1:0] map_mem  [MAP_CELLS];
  logic [31:0]       pal_mem  [PALETTE_SIZE];

  logic             busy_r, busy_nxt;
  logic [CLR_W-1:0] clr_idx_r, clr_idx_nxt;

  logic        adv;
  logic        a_valid_r, b_valid_r, c_valid_r, d_valid_r;
  tlr_item_t   a_item_r, b_item_r, c_item_r;
  logic [3:0]  c_bank_r;
  logic        c_tok_r, d_cov_r;
  logic [CELL_W-1:0] map_rd_r;
  logic [7:0]  tile_rd_r;
  logic [31:0] pal_rd_r;

  logic                   map_we, tile_we, pal_we;
  logic [MAP_IDX_W-1:0]   map_waddr;
  logic [CELL_W-1:0]      map_wdata;
  logic [TILE_ADDR_W-1:0] tile_waddr, tile_raddr;
  logic [7:0]             tile_wdata;
  logic [7:0]             pal_waddr, pal_raddr;
  logic [31:0]            pal_wdata;
  logic [8:0]             tidx;
  logic [13:0]            tile_raddr_full;
  logic [3:0]             nib;

  // power-up sweep clears all three stores
  always_comb begin
    busy_nxt    = busy_r;
    clr_idx_nxt = clr_idx_r;
    if (busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == CLR_W'(CLR_DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  assign busy  = busy_r;
  assign adv   = !d_valid_r || !out_stall;
  assign q_pop = adv && !q_empty && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= q_pop;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
      d_valid_r <= c_valid_r && (c_item_r.action == ACT_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r <= q_item;
      b_item_r <= a_item_r;
      c_item_r <= b_item_r;
      c_bank_r <= map_rd_r[12:9];
      c_tok_r  <= {1'b0, tidx} < 10'(TILE_COUNT);
      d_cov_r  <= c_item_r.en;
    end
  end

  // stage A: map cell
  always_comb begin
    if (busy_r) begin
      map_we    = {1'b0, clr_idx_r} < (CLR_W + 1)'(MAP_CELLS);
      map_waddr = clr_idx_r[MAP_IDX_W-1:0];
      map_wdata = '0;
    end else begin
      map_we    = adv && a_valid_r && a_item_r.en && (a_item_r.action == ACT_MAP);
      map_waddr = a_item_r.addr[MAP_IDX_W-1:0];
      map_wdata = a_item_r.data[CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (adv) begin
      map_rd_r <= map_mem[a_item_r.addr[MAP_IDX_W-1:0]];
    end
  end

  // stage B: tile byte
  assign tidx            = map_rd_r[8:0];
  assign tile_raddr_full = {tidx, b_item_r.pix[5:1]};
  assign tile_raddr      = tile_raddr_full[TILE_ADDR_W-1:0];

  always_comb begin
    if (busy_r) begin
      tile_we    = {1'b0, clr_idx_r} < (CLR_W + 1)'(TILESET_BYTES);
      tile_waddr = clr_idx_r[TILE_ADDR_W-1:0];
      tile_wdata = '0;
    end else begin
      tile_we    = adv && b_valid_r && b_item_r.en && (b_item_r.action == ACT_TILE);
      tile_waddr = b_item_r.addr[TILE_ADDR_W-1:0];
      tile_wdata = b_item_r.data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tile_we) begin
      tile_mem[tile_waddr] <= tile_wdata;
    end
    if (adv) begin
      tile_rd_r <= tile_mem[tile_raddr];
    end
  end

  // stage C: palette; left pixel sits in the high nibble
  assign nib       = !c_tok_r ? 4'd0 : (c_item_r.pix[0] ? tile_rd_r[3:0] : tile_rd_r[7:4]);
  assign pal_raddr = {c_bank_r, nib};

  always_comb begin
    if (busy_r) begin
      pal_we    = {1'b0, clr_idx_r} < (CLR_W + 1)'(PALETTE_SIZE);
      pal_waddr = clr_idx_r[7:0];
      pal_wdata = '0;
    end else begin
      pal_we    = adv && c_valid_r && c_item_r.en && (c_item_r.action == ACT_PAL);
      pal_waddr = c_item_r.addr[7:0];
      pal_wdata = c_item_r.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= pal_wdata;
    end
    if (adv) begin
      pal_rd_r <= pal_mem[pal_raddr];
    end
  end

  assign out_valid   = d_valid_r;
  assign out_covered = d_cov_r;
  assign out_color   = d_cov_r ? pal_rd_r : '0;

endmodule

// ===== rtl/tilemap_layer_pixel_renderer_unit.sv =====
// Scrolling 8x8 tilemap layer, 4 bits per pixel, with tileset, map and palette stores.
// Input channel (in_valid / in_stall): one item per accepted edge; in_action selects a
// tileset byte write, a map cell write, a palette write or a pixel render.
// Result channel (out_valid / out_stall): one item per render, none for writes.
// Config port: cfg_we writes cfg_wdata to scroll_x (index 0) or scroll_y (index 1);
// write it only while no item is in flight.
// Throughput: one item per cycle while in_stall is low. The front classifies an item and places it in a
// four-entry queue; the back pipeline reads map, tileset and palette in three
// chained stages, each with a registered memory read.
// A render result passes through the queue and stages A, B and C into registers that drive out_valid.
// Reset: synchronous, active low. Afterwards a sweep clears all stores, one entry per
// cycle; in_stall stays high until it ends.
// When out_stall is high while a result is valid, the back pipeline holds; the queue keeps taking items until
// it fills, then in_stall rises.
module tilemap_layer_pixel_renderer_unit #(
  parameter int MAP_LAST_COLUMN = tlr_pkg::MAP_LAST_COLUMN_DEF,
  parameter int MAP_LAST_ROW    = tlr_pkg::MAP_LAST_ROW_DEF,
  parameter int SCREEN_WIDTH    = tlr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT   = tlr_pkg::SCREEN_HEIGHT_DEF,
  parameter int TILE_COUNT      = tlr_pkg::TILE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [13:0] in_address,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_attrib,
  input  logic [7:0]  in_screen_x,
  input  logic [7:0]  in_screen_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_color,
  output logic        out_covered
);
  import tlr_pkg::*;

  logic      q_full, q_empty, q_push, q_pop, busy;
  tlr_item_t push_item, pop_item;

  tlr_front #(
    .MAP_LAST_COLUMN (MAP_LAST_COLUMN),
    .MAP_LAST_ROW    (MAP_LAST_ROW),
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .TILE_COUNT      (TILE_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_address  (in_address),
    .in_value    (in_value),
    .in_attrib   (in_attrib),
    .in_screen_x (in_screen_x),
    .in_screen_y (in_screen_y),
    .q_full      (q_full),
    .busy        (busy),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  tlr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  tlr_back #(
    .MAP_LAST_COLUMN (MAP_LAST_COLUMN),
    .MAP_LAST_ROW    (MAP_LAST_ROW),
    .TILE_COUNT      (TILE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_color   (out_color),
    .out_covered (out_covered)
  );

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result produced during store clearing");

  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_uncovered_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_covered |-> out_color == '0)
    else $error("uncovered pixel carries a color");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && !busy)
    else $error("pop from empty queue");

endmodule
